@@ rtl/core/bounded_stack_with_parity_filter_defines.svh @@
// Assertion macros shared by the stack sequencer.
// No dependencies; include by bare file name.
`ifndef BOUNDED_STACK_WITH_PARITY_FILTER_DEFINES_SVH
`define BOUNDED_STACK_WITH_PARITY_FILTER_DEFINES_SVH

// Same-cycle implication under reset.
`define BSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack check failed");

// Next-cycle implication under reset.
`define BSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack check failed");

`endif

@@ rtl/core/bsp_pkg.sv @@
// Shared types and constants for the bounded stack with parity filter.
// No dependencies.
`timescale 1ns / 1ps

package bsp_pkg;

    localparam int FUNC_W = 3;
    localparam int WORD_W = 32;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH      = 3'd0,
        OP_POP       = 3'd1,
        OP_PEEK      = 3'd2,
        OP_DROP_EVEN = 3'd3,
        OP_DROP_ODD  = 3'd4
    } op_e_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

@@ rtl/core/bsp_if.sv @@
// Valid/ready channel interfaces for stack operations and results.
// Depends on bsp_pkg.
`timescale 1ns / 1ps

interface bsp_in_if
    import bsp_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [WORD_W-1:0]  push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface bsp_out_if
    import bsp_pkg::*;
#(
    parameter int CNT_W = 7
);
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic signed [WORD_W-1:0]  read_value;
    logic [CNT_W-1:0]          occupancy;

    modport source (output valid, output ok, output read_value, output occupancy,
                    input ready);
    modport sink   (input valid, input ok, input read_value, input occupancy,
                    output ready);
endinterface

@@ rtl/core/bsp_mem.sv @@
// Stack storage: one write port and one registered read port.
// Depends on bsp_pkg.
`timescale 1ns / 1ps

module bsp_mem
    import bsp_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)(
    input  logic              clk,
    input  mem_ctl_t          mem_ctl,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] store_mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (mem_ctl.re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bsp_seq.sv @@
// Operation sequencer: decodes each item, walks storage for filters, holds the result.
// Depends on bsp_pkg, bsp_if and the assertion macro header.
`timescale 1ns / 1ps
`include "bounded_stack_with_parity_filter_defines.svh"

module bsp_seq
    import bsp_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CNT_W = 7
)(
    input  logic              clk,
    input  logic              rst_n,
    bsp_in_if.sink            cmd,
    bsp_out_if.source         res,
    output mem_ctl_t          mem_ctl,
    output logic [AW-1:0]     waddr,
    output logic [WORD_W-1:0] wdata,
    output logic [AW-1:0]     raddr,
    input  logic [WORD_W-1:0] rdata
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   kept_reg, kept_next;
    logic               pend_reg, pend_next;
    logic               parity_reg, parity_next;
    logic               ok_reg, ok_next;
    logic [WORD_W-1:0]  rd_reg, rd_next;
    logic               res_valid_reg, res_valid_next;
    logic               res_ok_reg, res_ok_next;
    logic [WORD_W-1:0]  res_rd_reg, res_rd_next;
    logic [CNT_W-1:0]   res_occ_reg, res_occ_next;

    logic               accept;
    logic               keep;
    logic               not_full;
    logic               not_empty;
    logic               more;
    logic               res_free;
    logic [CNT_W-1:0]   count_dec;
    op_e_t              op;

    assign op        = op_e_t'(cmd.func);
    assign accept    = cmd.valid && cmd.ready;
    assign keep      = (rdata[0] != parity_reg);
    assign not_full  = (count_reg < CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign more      = (rd_idx_reg < count_reg);
    assign res_free  = !res_valid_reg || res.ready;
    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_POP, OP_PEEK:
                        begin
                            state_next = not_empty ? S_READ : S_DONE;
                        end
                        OP_DROP_EVEN, OP_DROP_ODD:
                        begin
                            state_next = not_empty ? S_SCAN : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (!pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready  = (state_reg == S_IDLE);
        mem_ctl.we = 1'b0;
        mem_ctl.re = 1'b0;
        waddr      = count_reg[AW-1:0];
        wdata      = cmd.push_value;
        raddr      = count_dec[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_PUSH:
                        begin
                            mem_ctl.we = not_full;
                        end
                        OP_POP, OP_PEEK:
                        begin
                            mem_ctl.re = not_empty;
                        end
                        OP_DROP_EVEN, OP_DROP_ODD:
                        begin
                            mem_ctl.re = not_empty;
                            raddr      = '0;
                        end
                        default:
                        begin
                            mem_ctl.re = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                mem_ctl.we = pend_reg && keep;
                waddr      = kept_reg[AW-1:0];
                wdata      = rdata;
                mem_ctl.re = pend_reg && more;
                raddr      = rd_idx_reg[AW-1:0];
            end
            default:
            begin
                mem_ctl.we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        kept_next      = kept_reg;
        pend_next      = pend_reg;
        parity_next    = parity_reg;
        ok_next        = ok_reg;
        rd_next        = rd_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_ok_next    = res_ok_reg;
        res_rd_next    = res_rd_reg;
        res_occ_next   = res_occ_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ok_next = 1'b0;
                    rd_next = '0;
                    case (op)
                        OP_PUSH:
                        begin
                            if (not_full)
                            begin
                                count_next = count_reg + CNT_W'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (not_empty)
                            begin
                                count_next = count_dec;
                                ok_next    = 1'b1;
                            end
                        end
                        OP_PEEK:
                        begin
                            ok_next = not_empty;
                        end
                        OP_DROP_EVEN, OP_DROP_ODD:
                        begin
                            ok_next     = not_empty;
                            parity_next = (op == OP_DROP_ODD);
                            rd_idx_next = CNT_W'(1);
                            kept_next   = '0;
                            pend_next   = not_empty;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rd_next = rdata;
            end
            S_SCAN:
            begin
                if (pend_reg)
                begin
                    if (keep)
                    begin
                        kept_next = kept_reg + CNT_W'(1);
                    end
                    if (more)
                    begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                    pend_next = more;
                end
                else
                begin
                    count_next = kept_reg;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_ok_next    = ok_reg;
                    res_rd_next    = rd_reg;
                    res_occ_next   = count_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        kept_reg    <= kept_next;
        parity_reg  <= parity_next;
        ok_reg      <= ok_next;
        rd_reg      <= rd_next;
        res_ok_reg  <= res_ok_next;
        res_rd_reg  <= res_rd_next;
        res_occ_reg <= res_occ_next;
    end

    assign res.valid      = res_valid_reg;
    assign res.ok         = res_ok_reg;
    assign res.read_value = res_rd_reg;
    assign res.occupancy  = res_occ_reg;

    `BSP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `BSP_ASSERT_NOW(a_kept_behind, clk, rst_n, state_reg == S_SCAN, kept_reg <= rd_idx_reg)
    `BSP_ASSERT_NOW(a_no_port_clash, clk, rst_n, mem_ctl.we && mem_ctl.re, waddr != raddr)
    `BSP_ASSERT_NEXT(a_result_loads, clk, rst_n, state_reg == S_DONE && res_free, res.valid)

endmodule

@@ rtl/core/bounded_stack_with_parity_filter.sv @@
// Top level of the bounded LIFO stack with parity filter.
// Depends on bsp_pkg, bsp_if, bsp_mem and bsp_seq.
`timescale 1ns / 1ps

// One operation is taken at a time; cmd.ready is high only while the sequencer is idle.
// A push goes from idle straight to the done state, a pop or peek through a read state
// first (the storage read port is registered), and a filter through a scan state that
// streams each stored word once through the read port and writes survivors back through
// the write port. Fail cases and unused codes go straight to the done state. The result
// sits in an output register, so a new operation may start while the last result waits;
// it stalls only if a second result is ready before the first is taken. Storage has no
// reset; only written entries are ever read, so no clearing pass runs after reset.
module bounded_stack_with_parity_filter
    import bsp_pkg::*;
#(
    parameter int DEPTH = 64
)(
    input  logic      clk,
    input  logic      rst_n,
    bsp_in_if.sink    cmd,
    bsp_out_if.source res
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mem_ctl_t          mem_ctl;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [WORD_W-1:0] rdata;

    bsp_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CNT_W (CNT_W)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .res     (res),
        .mem_ctl (mem_ctl),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr   (raddr),
        .rdata   (rdata)
    );

    bsp_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr   (raddr),
        .rdata   (rdata)
    );

endmodule
